FILE: design/i2cbb_pkg.sv
`timescale 1ns / 1ps

package i2cbb_pkg;

  localparam int unsigned DLY_W = 16;
  localparam logic [31:0] DLY_MAX = 32'((64'd1 << DLY_W) - 64'd1);

  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HALF_PERIOD = 1'd0,
    REG_ACK_TIMEOUT = 1'd1
  } cfg_reg_e;

  localparam logic [15:0] HALF_PERIOD_RST = 16'd2;
  localparam logic [7:0]  ACK_TIMEOUT_RST = 8'd250;

  typedef enum logic [2:0] {
    CMD_NONE  = 3'd0,
    CMD_START = 3'd1,
    CMD_STOP  = 3'd2,
    CMD_WRITE = 3'd3,
    CMD_WACK  = 3'd4,
    CMD_READ  = 3'd5
  } cmd_e;

  typedef struct packed {
    logic [2:0] command;
    logic [7:0] tx_byte;
    logic       send_ack;
    logic       sda_in;
  } in_item_t;

  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic       sda_drive;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       ack_failed;
  } out_item_t;

endpackage

FILE: design/i2c_bit_bang_master_top.sv
`timescale 1ns / 1ps
// channel  direction  handshake              payload
// in       input      in_valid_i/in_stall_o  in_data_i  (in_item_t, one tick)
// out      output     out_valid_o/out_stall_i out_data_o (out_item_t, line levels)
// cfg      input      cfg_we_i               cfg_idx_i, cfg_data_i
// one tick per clock cycle while in_stall_o is low; the result appears in the output register in the cycle after
// the tick transaction, set by the single next-state logic between state and result
// in_stall_o rises only while a result is held and out_stall_i is high
// asynchronous reset clears all sequencer state and loads half_period 2, ack_timeout 250
// line timing is counted in ticks, so stalls only stretch wall-clock time

module i2c_bit_bang_master_top
  import i2cbb_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  in_item_t              in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output out_item_t             out_data_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  typedef enum logic [14:0] {
    PH_IDLE = 15'b000000000000001,
    PH_ST1  = 15'b000000000000010,
    PH_ST2  = 15'b000000000000100,
    PH_ST3  = 15'b000000000001000,
    PH_SP1  = 15'b000000000010000,
    PH_SP2  = 15'b000000000100000,
    PH_WA1  = 15'b000000001000000,
    PH_WA2  = 15'b000000010000000,
    PH_WAP  = 15'b000000100000000,
    PH_WRH  = 15'b000001000000000,
    PH_WRL  = 15'b000010000000000,
    PH_RDL  = 15'b000100000000000,
    PH_RDH  = 15'b001000000000000,
    PH_AK1  = 15'b010000000000000,
    PH_AK2  = 15'b100000000000000
  } phase_e;

  logic [15:0]      half_period_q;
  logic [7:0]       ack_timeout_q;

  phase_e           phase_q, phase_d;
  logic [3:0]       bit_cnt_q, bit_cnt_d;
  logic [7:0]       shift_q, shift_d;
  logic [DLY_W-1:0] dly_q, dly_d;
  logic [8:0]       wait_q, wait_d;
  logic             scl_q, scl_d;
  logic             sda_q, sda_d;
  logic             drive_q, drive_d;
  logic             fail_q, fail_d;
  logic [7:0]       rx_q, rx_d;
  logic             ack_sel_q, ack_sel_d;
  logic             done;

  logic             out_valid_q;
  out_item_t        out_q;

  logic             in_fire;
  logic [31:0]      hp_sat;
  logic [DLY_W-1:0] dly_arm;
  logic [8:0]       wait_inc;

  assign in_stall_o  = out_valid_q && out_stall_i;
  assign in_fire     = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // hold length in ticks, saturated to the counter, zero acts as one
  always_comb begin
    hp_sat = 32'(half_period_q);
    if (hp_sat > DLY_MAX) begin
      hp_sat = DLY_MAX;
    end
    if (hp_sat == 32'd0) begin
      hp_sat = 32'd1;
    end
    dly_arm = DLY_W'(hp_sat - 32'd1);
  end

  assign wait_inc = wait_q + 9'd1;

  always_comb begin
    phase_d   = phase_q;
    bit_cnt_d = bit_cnt_q;
    shift_d   = shift_q;
    dly_d     = dly_q;
    wait_d    = wait_q;
    scl_d     = scl_q;
    sda_d     = sda_q;
    drive_d   = drive_q;
    fail_d    = fail_q;
    rx_d      = rx_q;
    ack_sel_d = ack_sel_q;
    done      = 1'b0;
    if (in_fire) begin
      if (phase_q == PH_IDLE) begin
        unique case (in_data_i.command)
          CMD_START: begin
            drive_d = 1'b1;
            sda_d   = 1'b1;
            scl_d   = 1'b1;
            phase_d = PH_ST1;
            dly_d   = dly_arm;
          end
          CMD_STOP: begin
            drive_d = 1'b1;
            scl_d   = 1'b0;
            sda_d   = 1'b0;
            phase_d = PH_SP1;
            dly_d   = dly_arm;
          end
          CMD_WRITE: begin
            drive_d   = 1'b1;
            bit_cnt_d = 4'd0;
            sda_d     = in_data_i.tx_byte[7];
            shift_d   = {in_data_i.tx_byte[6:0], 1'b0};
            scl_d     = 1'b1;
            phase_d   = PH_WRH;
            dly_d     = dly_arm;
          end
          CMD_WACK: begin
            drive_d = 1'b0;
            sda_d   = 1'b1;
            wait_d  = 9'd0;
            fail_d  = 1'b0;
            phase_d = PH_WA1;
            dly_d   = dly_arm;
          end
          CMD_READ: begin
            drive_d   = 1'b0;
            scl_d     = 1'b0;
            shift_d   = 8'd0;
            bit_cnt_d = 4'd0;
            ack_sel_d = in_data_i.send_ack;
            phase_d   = PH_RDL;
            dly_d     = dly_arm;
          end
          default: begin
          end
        endcase
      end else if (dly_q != '0) begin
        dly_d = dly_q - DLY_W'(1);
      end else begin
        unique case (phase_q)
          PH_ST1: begin
            sda_d   = 1'b0;
            phase_d = PH_ST2;
            dly_d   = dly_arm;
          end
          PH_ST2: begin
            scl_d   = 1'b0;
            phase_d = PH_ST3;
            dly_d   = dly_arm;
          end
          PH_SP1: begin
            scl_d   = 1'b1;
            sda_d   = 1'b1;
            phase_d = PH_SP2;
            dly_d   = dly_arm;
          end
          PH_WA1: begin
            scl_d   = 1'b1;
            phase_d = PH_WA2;
            dly_d   = dly_arm;
          end
          PH_WA2, PH_WAP: begin
            if (!in_data_i.sda_in) begin
              scl_d   = 1'b0;
              phase_d = PH_IDLE;
              done    = 1'b1;
            end else begin
              wait_d = wait_inc;
              if (wait_inc > {1'b0, ack_timeout_q}) begin
                fail_d  = 1'b1;
                drive_d = 1'b1;
                scl_d   = 1'b0;
                sda_d   = 1'b0;
                phase_d = PH_SP1;
                dly_d   = dly_arm;
              end else begin
                phase_d = PH_WAP;
              end
            end
          end
          PH_WRH: begin
            scl_d   = 1'b0;
            phase_d = PH_WRL;
            dly_d   = dly_arm;
          end
          PH_WRL: begin
            bit_cnt_d = bit_cnt_q + 4'd1;
            if (bit_cnt_d >= 4'd8) begin
              phase_d = PH_IDLE;
              done    = 1'b1;
            end else begin
              sda_d   = shift_q[7];
              shift_d = {shift_q[6:0], 1'b0};
              scl_d   = 1'b1;
              phase_d = PH_WRH;
              dly_d   = dly_arm;
            end
          end
          PH_RDL: begin
            scl_d     = 1'b1;
            shift_d   = {shift_q[6:0], in_data_i.sda_in};
            bit_cnt_d = bit_cnt_q + 4'd1;
            phase_d   = PH_RDH;
            dly_d     = dly_arm;
          end
          PH_RDH: begin
            scl_d = 1'b0;
            dly_d = dly_arm;
            if (bit_cnt_q >= 4'd8) begin
              drive_d = 1'b1;
              sda_d   = !ack_sel_q;
              phase_d = PH_AK1;
            end else begin
              phase_d = PH_RDL;
            end
          end
          PH_AK1: begin
            scl_d   = 1'b1;
            phase_d = PH_AK2;
            dly_d   = dly_arm;
          end
          PH_AK2: begin
            scl_d   = 1'b0;
            rx_d    = shift_q;
            phase_d = PH_IDLE;
            done    = 1'b1;
          end
          default: begin
            phase_d = PH_IDLE;
            done    = 1'b1;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_period_q <= HALF_PERIOD_RST;
      ack_timeout_q <= ACK_TIMEOUT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_HALF_PERIOD: half_period_q <= cfg_data_i[15:0];
        REG_ACK_TIMEOUT: ack_timeout_q <= cfg_data_i[7:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      bit_cnt_q <= '0;
      shift_q   <= '0;
      dly_q     <= '0;
      wait_q    <= '0;
      scl_q     <= 1'b1;
      sda_q     <= 1'b1;
      drive_q   <= 1'b1;
      fail_q    <= 1'b0;
      rx_q      <= '0;
      ack_sel_q <= 1'b0;
    end else begin
      phase_q   <= phase_d;
      bit_cnt_q <= bit_cnt_d;
      shift_q   <= shift_d;
      dly_q     <= dly_d;
      wait_q    <= wait_d;
      scl_q     <= scl_d;
      sda_q     <= sda_d;
      drive_q   <= drive_d;
      fail_q    <= fail_d;
      rx_q      <= rx_d;
      ack_sel_q <= ack_sel_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      out_q.scl_out    <= scl_d;
      out_q.sda_out    <= sda_d;
      out_q.sda_drive  <= drive_d;
      out_q.busy_res   <= (phase_d != PH_IDLE);
      out_q.done_res   <= done;
      out_q.rx_byte    <= rx_d;
      out_q.ack_failed <= fail_d;
    end
  end

endmodule

FILE: design/i2cbb_checker.sv
`timescale 1ns / 1ps

module i2cbb_checker
  import i2cbb_pkg::*;
(
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_stall_o,
  input logic                  out_valid_o,
  input logic                  out_stall_i,
  input out_item_t             out_data_o
);

  logic last_busy_q;
  logic out_fire;

  assign out_fire = out_valid_o && !out_stall_i;

  // busy level of the last delivered transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_busy_q <= 1'b0;
    end else if (out_fire) begin
      last_busy_q <= out_data_o.busy_res;
    end
  end

  a_tick_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> out_valid_o)
    else $error("accepted tick produced no result");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_data_o)))
    else $error("stalled result changed");

  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.done_res) |-> !out_data_o.busy_res)
    else $error("done reported while still busy");

  a_busy_ends_with_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_fire && last_busy_q && !out_data_o.busy_res) |-> out_data_o.done_res)
    else $error("command ended without done");

  a_empty_never_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled with empty result register");

endmodule

bind i2c_bit_bang_master_top i2cbb_checker u_i2cbb_checker (.*);

FILE: tb/i2c_bit_bang_master_checker.sv
`timescale 1ns / 1ps

module i2c_bit_bang_master_checker
  import i2cbb_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_stall_i,
  input  in_item_t              in_data_i,
  input  logic                  out_valid_i,
  input  logic                  out_stall_i,
  input  out_item_t             out_data_i,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output int                    err_count_o,
  output int                    pending_o
);

  typedef enum logic [4:0] {
    SEQ_IDLE,
    SEQ_START_SDA,
    SEQ_START_SCL,
    SEQ_START_END,
    SEQ_STOP_RISE,
    SEQ_STOP_END,
    SEQ_ACK_SCL,
    SEQ_ACK_FIRST,
    SEQ_ACK_POLL,
    SEQ_WR_HIGH,
    SEQ_WR_LOW,
    SEQ_RD_LOW,
    SEQ_RD_HIGH,
    SEQ_MACK_LOW,
    SEQ_MACK_HIGH
  } seq_phase_e;

  seq_phase_e  phase;
  logic [3:0]  bit_cnt;
  logic [7:0]  shift_q;
  logic [15:0] hold_cnt;
  logic [8:0]  poll_cnt;
  logic        scl_q;
  logic        sda_q;
  logic        sda_oe;
  logic        ack_fail;
  logic        mack_sel;
  logic [7:0]  rx_q;
  logic [15:0] half_period;
  logic [7:0]  ack_timeout;

  out_item_t   line_q[$];

  task automatic load_defaults();
    half_period = HALF_PERIOD_RST;
    ack_timeout = ACK_TIMEOUT_RST;
    phase       = SEQ_IDLE;
    bit_cnt     = '0;
    shift_q     = '0;
    hold_cnt    = '0;
    poll_cnt    = '0;
    scl_q       = 1'b1;
    sda_q       = 1'b1;
    sda_oe      = 1'b1;
    ack_fail    = 1'b0;
    mack_sel    = 1'b0;
    rx_q        = '0;
  endtask

  // a zero half period behaves as one tick
  task automatic hold_in(input seq_phase_e nxt);
    phase    = nxt;
    hold_cnt = (half_period == '0) ? '0 : half_period - 16'd1;
  endtask

  task automatic stop_begin();
    sda_oe = 1'b1;
    scl_q  = 1'b0;
    sda_q  = 1'b0;
    hold_in(SEQ_STOP_RISE);
  endtask

  task automatic next_bit_out();
    sda_q   = shift_q[7];
    shift_q = {shift_q[6:0], 1'b0};
    scl_q   = 1'b1;
    hold_in(SEQ_WR_HIGH);
  endtask

  task automatic predict_tick(input in_item_t it, output out_item_t res);
    logic done;
    done = 1'b0;
    if (phase == SEQ_IDLE) begin
      case (it.command)
        CMD_START: begin
          sda_oe = 1'b1;
          sda_q  = 1'b1;
          scl_q  = 1'b1;
          hold_in(SEQ_START_SDA);
        end
        CMD_STOP: stop_begin();
        CMD_WRITE: begin
          sda_oe  = 1'b1;
          scl_q   = 1'b0;
          shift_q = it.tx_byte;
          bit_cnt = '0;
          next_bit_out();
        end
        CMD_WACK: begin
          sda_oe   = 1'b0;
          sda_q    = 1'b1;
          poll_cnt = '0;
          ack_fail = 1'b0;
          hold_in(SEQ_ACK_SCL);
        end
        CMD_READ: begin
          sda_oe   = 1'b0;
          scl_q    = 1'b0;
          shift_q  = '0;
          bit_cnt  = '0;
          mack_sel = it.send_ack;
          hold_in(SEQ_RD_LOW);
        end
        default: ;
      endcase
    end else if (hold_cnt != '0) begin
      hold_cnt = hold_cnt - 16'd1;
    end else begin
      case (phase)
        SEQ_START_SDA: begin
          sda_q = 1'b0;
          hold_in(SEQ_START_SCL);
        end
        SEQ_START_SCL: begin
          scl_q = 1'b0;
          hold_in(SEQ_START_END);
        end
        SEQ_STOP_RISE: begin
          scl_q = 1'b1;
          sda_q = 1'b1;
          hold_in(SEQ_STOP_END);
        end
        SEQ_ACK_SCL: begin
          scl_q = 1'b1;
          hold_in(SEQ_ACK_FIRST);
        end
        SEQ_ACK_FIRST, SEQ_ACK_POLL: begin
          if (!it.sda_in) begin
            scl_q = 1'b0;
            phase = SEQ_IDLE;
            done  = 1'b1;
          end else begin
            poll_cnt = poll_cnt + 9'd1;
            if (poll_cnt > {1'b0, ack_timeout}) begin
              ack_fail = 1'b1;
              stop_begin();
            end else begin
              phase = SEQ_ACK_POLL;
            end
          end
        end
        SEQ_WR_HIGH: begin
          scl_q = 1'b0;
          hold_in(SEQ_WR_LOW);
        end
        SEQ_WR_LOW: begin
          bit_cnt = bit_cnt + 4'd1;
          if (bit_cnt >= 4'd8) begin
            phase = SEQ_IDLE;
            done  = 1'b1;
          end else begin
            next_bit_out();
          end
        end
        SEQ_RD_LOW: begin
          scl_q   = 1'b1;
          shift_q = {shift_q[6:0], it.sda_in};
          bit_cnt = bit_cnt + 4'd1;
          hold_in(SEQ_RD_HIGH);
        end
        SEQ_RD_HIGH: begin
          scl_q = 1'b0;
          if (bit_cnt >= 4'd8) begin
            sda_oe = 1'b1;
            sda_q  = !mack_sel;
            hold_in(SEQ_MACK_LOW);
          end else begin
            hold_in(SEQ_RD_LOW);
          end
        end
        SEQ_MACK_LOW: begin
          scl_q = 1'b1;
          hold_in(SEQ_MACK_HIGH);
        end
        SEQ_MACK_HIGH: begin
          scl_q = 1'b0;
          rx_q  = shift_q;
          phase = SEQ_IDLE;
          done  = 1'b1;
        end
        default: begin
          phase = SEQ_IDLE;
          done  = 1'b1;
        end
      endcase
    end
    res.scl_out    = scl_q;
    res.sda_out    = sda_q;
    res.sda_drive  = sda_oe;
    res.busy_res   = (phase != SEQ_IDLE);
    res.done_res   = done;
    res.rx_byte    = rx_q;
    res.ack_failed = ack_fail;
  endtask

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      err_count_o++;
    end
  endtask

  task automatic check_result(input out_item_t got);
    out_item_t want;
    if (line_q.size() == 0) begin
      $display("%0t: unexpected result transaction, actual %h", $time, got);
      err_count_o++;
    end else begin
      want = line_q.pop_front();
      check_field("scl_out", 8'(want.scl_out), 8'(got.scl_out));
      check_field("sda_out", 8'(want.sda_out), 8'(got.sda_out));
      check_field("sda_drive", 8'(want.sda_drive), 8'(got.sda_drive));
      check_field("busy_res", 8'(want.busy_res), 8'(got.busy_res));
      check_field("done_res", 8'(want.done_res), 8'(got.done_res));
      check_field("rx_byte", want.rx_byte, got.rx_byte);
      check_field("ack_failed", 8'(want.ack_failed), 8'(got.ack_failed));
    end
  endtask

  // inputs only change at rising edges, so the falling edge sees what the next edge takes
  always @(negedge clk_i) begin : watch
    out_item_t want;
    if (!rst_ni) begin
      load_defaults();
      line_q.delete();
      err_count_o = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_idx_i))
          REG_HALF_PERIOD: half_period = cfg_data_i;
          REG_ACK_TIMEOUT: ack_timeout = cfg_data_i[7:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        predict_tick(in_data_i, want);
        line_q.push_back(want);
      end
      if (out_valid_i && !out_stall_i) begin
        check_result(out_data_i);
      end
    end
    pending_o = line_q.size();
  end

endmodule

FILE: tb/tb_i2c_bit_bang_master_top.sv
`timescale 1ns / 1ps

module tb_i2c_bit_bang_master_top;
  import i2cbb_pkg::*;

  localparam int unsigned NUM_TICKS   = 750;
  localparam int unsigned CFG_EVERY   = 80;
  localparam int unsigned QUIET_FROM  = 300;
  localparam int unsigned QUIET_TO    = 420;
  localparam int unsigned CYCLE_LIMIT = 2_000_000;
  localparam int unsigned IDLE_PCT    = 18;
  localparam int unsigned NEVER_LOW   = 32'hFFFF_FFFF;
  localparam int unsigned SDA_RANDOM  = 32'hFFFF_FFFE;

  // codes outside the command set, which the sequencer treats as no command
  localparam logic [2:0] CMD_SPARE_LO = 3'd6;
  localparam logic [2:0] CMD_SPARE_HI = 3'd7;

  logic                  clk;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  in_item_t              in_data   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_item_t             out_data;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx   = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  int                    err_count;
  int                    pending;
  int unsigned           sent_cnt     = 0;
  int unsigned           rcv_cnt      = 0;
  int unsigned           cycle_cnt    = 0;
  int unsigned           started      = 0;
  int unsigned           cfg_sets     = 0;
  int unsigned           ack_timeouts = 0;
  int unsigned           per_code[8];
  int unsigned           cur_hp       = 32'(HALF_PERIOD_RST);
  int unsigned           cur_to       = 32'(ACK_TIMEOUT_RST);
  logic                  last_busy    = 1'b0;
  logic                  last_fail    = 1'b0;
  logic                  quiet        = 1'b0;

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  i2c_bit_bang_master_top i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data)
  );

  i2c_bit_bang_master_checker i_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .in_data_i   (in_data),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .out_data_i  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data),
    .err_count_o (err_count),
    .pending_o   (pending)
  );

  // stretch of ticks with no idling on either side
  always @(posedge clk) begin
    quiet <= (sent_cnt >= QUIET_FROM) && (sent_cnt < QUIET_TO);
  end

  always @(posedge clk) begin
    out_stall <= rst_n && !quiet && ($urandom_range(99) < IDLE_PCT);
  end

  always @(negedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      rcv_cnt++;
      last_busy = out_data.busy_res;
      if (out_data.ack_failed && !last_fail) ack_timeouts++;
      last_fail = out_data.ack_failed;
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("cycle limit %0d hit with %0d results outstanding", CYCLE_LIMIT, pending);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic send_tick(input in_item_t item);
    logic taken;
    while (!quiet && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_data  <= item;
    in_valid <= 1'b1;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end
    sent_cnt++;
  endtask

  function automatic logic sda_at(input int unsigned ofs, input int unsigned low_at);
    if (low_at == SDA_RANDOM) return 1'($urandom);
    return ofs < low_at;
  endfunction

  // ack arrives early, somewhere across the timeout window, or never
  function automatic int unsigned ack_low_at();
    int unsigned hp_eff;
    int unsigned pick;
    hp_eff = (cur_hp == 0) ? 1 : cur_hp;
    pick   = $urandom_range(99);
    if (pick < 70) return $urandom_range(2 * hp_eff + 2, 0);
    if (pick < 85) return $urandom_range(2 * hp_eff + cur_to + 4, 0);
    return NEVER_LOW;
  endfunction

  // one command tick, then ticks until the sequencer reports idle again; the two ticks right
  // after a real command may carry random codes and always land while it is busy
  task automatic run_cmd(input logic [2:0] code, input logic [7:0] tx, input logic ack,
                         input int unsigned low_at);
    in_item_t    item;
    int unsigned ofs;
    int unsigned cmd_idx;
    logic        real_cmd;
    ofs           = 0;
    cmd_idx       = sent_cnt;
    real_cmd      = (code >= CMD_START) && (code <= CMD_READ);
    item.command  = code;
    item.tx_byte  = tx;
    item.send_ack = ack;
    item.sda_in   = sda_at(ofs, low_at);
    send_tick(item);
    per_code[code]++;
    if (real_cmd) started++;
    while (!(rcv_cnt > cmd_idx && !last_busy)) begin
      ofs++;
      item.command  = (real_cmd && ofs <= 2 && $urandom_range(1)) ? 3'($urandom_range(7))
                                                                  : CMD_NONE;
      item.tx_byte  = 8'($urandom);
      item.send_ack = 1'($urandom);
      item.sda_in   = sda_at(ofs, low_at);
      send_tick(item);
    end
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [CFG_DATA_W-1:0] value);
    in_valid <= 1'b0;
    while (rcv_cnt != sent_cnt || last_busy) @(posedge clk);
    repeat (2) @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we   <= 1'b0;
  endtask

  task automatic set_config(input logic [15:0] hp, input logic [7:0] to);
    write_reg(REG_HALF_PERIOD, hp);
    write_reg(REG_ACK_TIMEOUT, CFG_DATA_W'(to));
    cur_hp = 32'(hp);
    cur_to = 32'(to);
    cfg_sets++;
  endtask

  initial begin
    int unsigned next_cfg;
    int unsigned n_data;
    logic [15:0] hp;
    logic [7:0]  to;
    logic        is_read;
    logic [2:0]  code;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings
    run_cmd(CMD_NONE, 8'h00, 1'b0, SDA_RANDOM);
    run_cmd(CMD_START, 8'hFF, 1'b1, SDA_RANDOM);
    run_cmd(CMD_WRITE, 8'hFF, 1'b0, SDA_RANDOM);
    run_cmd(CMD_WACK, 8'h00, 1'b0, 0);
    run_cmd(CMD_WRITE, 8'h00, 1'b1, SDA_RANDOM);
    run_cmd(CMD_WACK, 8'hFF, 1'b1, 10);
    run_cmd(CMD_READ, 8'h00, 1'b1, NEVER_LOW);
    run_cmd(CMD_READ, 8'hFF, 1'b0, 0);
    run_cmd(CMD_READ, 8'h5A, 1'b1, SDA_RANDOM);
    run_cmd(CMD_STOP, 8'hA5, 1'b0, SDA_RANDOM);
    run_cmd(CMD_SPARE_LO, 8'hFF, 1'b1, SDA_RANDOM);
    run_cmd(CMD_SPARE_HI, 8'h00, 1'b0, SDA_RANDOM);

    // zero half period and zero ack timeout
    set_config(16'd0, 8'd0);
    run_cmd(CMD_START, 8'h00, 1'b0, SDA_RANDOM);
    run_cmd(CMD_WRITE, 8'hA5, 1'b0, SDA_RANDOM);
    run_cmd(CMD_WACK, 8'h00, 1'b0, NEVER_LOW);
    run_cmd(CMD_STOP, 8'h00, 1'b0, SDA_RANDOM);
    run_cmd(CMD_WACK, 8'h00, 1'b0, 0);
    run_cmd(CMD_STOP, 8'h00, 1'b0, SDA_RANDOM);

    // longest ack wait
    set_config(16'd1, 8'd255);
    run_cmd(CMD_WACK, 8'h3C, 1'b1, NEVER_LOW);
    run_cmd(CMD_READ, 8'hC3, 1'b0, SDA_RANDOM);

    // longer half period
    set_config(16'd9, 8'd3);
    run_cmd(CMD_STOP, 8'h00, 1'b1, SDA_RANDOM);

    next_cfg = sent_cnt;
    while (sent_cnt < NUM_TICKS) begin
      if (sent_cnt >= next_cfg) begin
        case ($urandom_range(4))
          0:       hp = 16'd0;
          1:       hp = 16'd1;
          default: hp = 16'($urandom_range(4, 2));
        endcase
        case ($urandom_range(5))
          0:       to = 8'd0;
          1:       to = 8'd255;
          default: to = 8'($urandom_range(24, 1));
        endcase
        set_config(hp, to);
        next_cfg = sent_cnt + CFG_EVERY;
      end

      if ($urandom_range(99) < 80) begin
        // addressed transfer: start, address, ack, data phase, usually a stop
        run_cmd(CMD_START, 8'($urandom), 1'($urandom), SDA_RANDOM);
        run_cmd(CMD_WRITE, 8'($urandom), 1'($urandom), SDA_RANDOM);
        run_cmd(CMD_WACK, 8'($urandom), 1'($urandom), ack_low_at());
        is_read = 1'($urandom);
        n_data  = $urandom_range(2, 1);
        for (int unsigned i = 0; i < n_data; i++) begin
          if (is_read) begin
            run_cmd(CMD_READ, 8'($urandom),
                    (i + 1 < n_data) ? ($urandom_range(9) != 0) : ($urandom_range(9) == 0),
                    SDA_RANDOM);
          end else begin
            run_cmd(CMD_WRITE, 8'($urandom), 1'($urandom), SDA_RANDOM);
            run_cmd(CMD_WACK, 8'($urandom), 1'($urandom), ack_low_at());
          end
          if ($urandom_range(19) == 0) begin
            run_cmd(CMD_START, 8'($urandom), 1'($urandom), SDA_RANDOM);
          end
        end
        if ($urandom_range(9) != 0) begin
          run_cmd(CMD_STOP, 8'($urandom), 1'($urandom), SDA_RANDOM);
        end
      end else begin
        code = 3'($urandom_range(7));
        run_cmd(code, 8'($urandom), 1'($urandom),
                (code == CMD_WACK) ? ack_low_at() : SDA_RANDOM);
      end
    end

    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("%0d ticks driven, %0d bus commands run under %0d register settings",
             sent_cnt, started, cfg_sets);
    $display("start %0d, stop %0d, write %0d, ack wait %0d, read %0d, ack timeouts %0d",
             per_code[CMD_START], per_code[CMD_STOP], per_code[CMD_WRITE],
             per_code[CMD_WACK], per_code[CMD_READ], ack_timeouts);
    if (err_count == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

FILE: sim.f
design/i2cbb_pkg.sv
design/i2c_bit_bang_master_top.sv
design/i2cbb_checker.sv
tb/i2c_bit_bang_master_checker.sv
tb/tb_i2c_bit_bang_master_top.sv
